// File: rtl/core/synced_trapezoid_motion_profile_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motion profile core
// Each macro expands to a labelled concurrent assertion, or to nothing when
// ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SYNCED_TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`define SYNCED_TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`ifndef ASSERT_OFF
`define STMP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("stmp assertion failed");
`define STMP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) else $error("stmp assertion failed");
`else
`define STMP_ASSERT(lbl, prop)
`define STMP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: rtl/core/stmp_pkg.sv
// ----------------------------------------------------------------------------
// Motion profile package
// Shared constants, types and saturation helpers.
// ----------------------------------------------------------------------------
package stmp_pkg;

	localparam int MAX_JOINTS = 8;
	localparam int JIDX_W     = 3;
	localparam int JCNT_W     = 4;
	localparam int FRAC_BITS  = 16;
	localparam int TDATA_W    = 72;

	localparam logic [31:0] TIME_MAX    = 32'hFFFF_FFFE;
	localparam logic [31:0] ELAPSED_MAX = 32'hFFFF_FFFF;
	localparam logic [40:0] WIDE_CAP    = 41'h100_0000_0000;

	localparam logic [1:0] REG_VLIM = 2'd0;
	localparam logic [1:0] REG_ALIM = 2'd1;
	localparam logic [1:0] REG_TICK = 2'd2;
	localparam logic [1:0] REG_JCNT = 2'd3;

	localparam logic [1:0] SEG_ACC = 2'd0;
	localparam logic [1:0] SEG_CRU = 2'd1;
	localparam logic [1:0] SEG_DEC = 2'd2;
	localparam logic [1:0] SEG_END = 2'd3;

	typedef struct packed {
		logic              we;
		logic [JIDX_W-1:0] addr;
		logic [63:0]       data;
	} mem_wr_t;

	function automatic logic [31:0] sat_time(input logic [65:0] x);
		return (x > 66'(TIME_MAX)) ? TIME_MAX : x[31:0];
	endfunction

	function automatic logic [40:0] sat_wide(input logic [73:0] x);
		return (x > 74'(WIDE_CAP)) ? WIDE_CAP : x[40:0];
	endfunction

	function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		logic [32:0] nd;
		d  = {b[31], b} - {a[31], a};
		nd = -d;
		return d[32] ? nd[31:0] : d[31:0];
	endfunction

	function automatic logic [31:0] clamp32(input logic signed [43:0] x);
		logic [31:0] r;
		if (x > 44'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (x < -44'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/stmp_jstore.sv
// ----------------------------------------------------------------------------
// Joint store
// Two synchronous memories, endpoint angles and profile terms, with one
// registered read port each and valid bits that make unwritten entries zero.
// ----------------------------------------------------------------------------
module stmp_jstore (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stmp_pkg::mem_wr_t             ang_wr,
	input  stmp_pkg::mem_wr_t             prof_wr,
	input  logic                          prof_clr,
	input  logic [stmp_pkg::JIDX_W-1:0]   raddr,
	output logic [63:0]                   ang_rdata,
	output logic [63:0]                   prof_rdata
);

	logic [63:0] ang_mem [stmp_pkg::MAX_JOINTS];
	logic [63:0] prof_mem [stmp_pkg::MAX_JOINTS];
	logic [stmp_pkg::MAX_JOINTS-1:0] ang_vld_q;
	logic [stmp_pkg::MAX_JOINTS-1:0] prof_vld_q;
	logic [63:0] ang_rd_s1;
	logic [63:0] prof_rd_s1;
	logic        ang_vld_s1;
	logic        prof_vld_s1;

	always_ff @(posedge clk) begin
		if (ang_wr.we) begin
			ang_mem[ang_wr.addr] <= ang_wr.data;
		end
		if (prof_wr.we) begin
			prof_mem[prof_wr.addr] <= prof_wr.data;
		end
		ang_rd_s1  <= ang_mem[raddr];
		prof_rd_s1 <= prof_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_vld_q   <= '0;
			prof_vld_q  <= '0;
			ang_vld_s1  <= 1'b0;
			prof_vld_s1 <= 1'b0;
		end else begin
			if (ang_wr.we) begin
				ang_vld_q[ang_wr.addr] <= 1'b1;
			end
			if (prof_clr) begin
				prof_vld_q <= '0;
			end else if (prof_wr.we) begin
				prof_vld_q[prof_wr.addr] <= 1'b1;
			end
			ang_vld_s1  <= ang_vld_q[raddr];
			prof_vld_s1 <= prof_vld_q[raddr];
		end
	end

	assign ang_rdata  = ang_vld_s1 ? ang_rd_s1 : '0;
	assign prof_rdata = prof_vld_s1 ? prof_rd_s1 : '0;

endmodule

// File: rtl/core/stmp_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned 64 by 32 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stmp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        busy,
	output logic        done,
	output logic [63:0] quot
);

	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] remsh;
	logic [32:0] rem_n;
	logic        qbit;

	always_comb begin
		remsh = {rem_q, quo_q[63]};
		qbit  = (remsh >= {1'b0, den_q});
		rem_n = qbit ? (remsh - {1'b0, den_q}) : remsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
				cnt_q  <= 6'd63;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= rem_n[31:0];
				quo_q <= {quo_q[62:0], qbit};
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

endmodule

// File: rtl/core/stmp_sqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module stmp_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	logic [63:0] rad_q;
	logic [31:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] remsh;
	logic [33:0] trial;
	logic [33:0] rem_n;
	logic        rbit;

	always_comb begin
		remsh = {rem_q, rad_q[63:62]};
		trial = {root_q, 2'b01};
		rbit  = (remsh >= trial);
		rem_n = rbit ? (remsh - trial) : remsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= radicand;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= 5'd31;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q  <= {rad_q[61:0], 2'b00};
				rem_q  <= rem_n[31:0];
				root_q <= {root_q[30:0], rbit};
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 5'd1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: rtl/core/synced_trapezoid_motion_profile.sv
// ----------------------------------------------------------------------------
// Synchronised trapezoidal motion profile
// Plans a shared trapezoidal or triangular move over all joints in use and
// emits one position and velocity setpoint per joint on every tick until its final setpoints are out.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         tuser: cmd; tdata: joint_index, start_pos, end_pos;
//                       tlast: last_joint
//  m_*       out        tuser: done_res; tdata: joint_id, position, velocity;
//                       tlast: last
//  APB       in         registers at 0x0, 0x4, 0x8, 0xC
//
// A load is stored when taken; the load that plans runs the lead search and time plan
// (a triangular move takes a square root in place of the second division), then
// works out the terms of each joint in turn through the shared divider.
// A tick works through each joint in turn with the shared multiplier.
// No input transfer is taken while a setpoint waits; reset needs no sweep.
`include "synced_trapezoid_motion_profile_macros.svh"

module synced_trapezoid_motion_profile (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [2:0] joint_index, [34:3] start_pos, [66:35] end_pos, zero above
	input  logic [stmp_pkg::TDATA_W-1:0]   s_tdata,
	// [0] cmd
	input  logic [0:0]                     s_tuser,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [2:0] joint_id, [34:3] position, [66:35] velocity, zero above
	output logic [stmp_pkg::TDATA_W-1:0]   m_tdata,
	// [0] done_res
	output logic [0:0]                     m_tuser,
	output logic                           m_tlast,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [3:0]                     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	typedef enum logic [27:0] {
		ST_IDLE   = 28'h0000001,
		ST_P_RD   = 28'h0000002,
		ST_P_MAG  = 28'h0000004,
		ST_P_CHK  = 28'h0000008,
		ST_P_M1   = 28'h0000010,
		ST_P_M2   = 28'h0000020,
		ST_P_M3   = 28'h0000040,
		ST_P_TA   = 28'h0000080,
		ST_P_TT   = 28'h0000100,
		ST_P_TRI  = 28'h0000200,
		ST_P_SQ   = 28'h0000400,
		ST_P_JRD  = 28'h0000800,
		ST_P_JMAG = 28'h0001000,
		ST_P_JM1  = 28'h0002000,
		ST_P_JM2  = 28'h0004000,
		ST_P_JVM  = 28'h0008000,
		ST_P_JAM  = 28'h0010000,
		ST_P_JWR  = 28'h0020000,
		ST_T_RD   = 28'h0040000,
		ST_T_LD   = 28'h0080000,
		ST_T_V1   = 28'h0100000,
		ST_T_V2   = 28'h0200000,
		ST_T_O0   = 28'h0400000,
		ST_T_O1   = 28'h0800000,
		ST_T_O2   = 28'h1000000,
		ST_T_O3   = 28'h2000000,
		ST_T_OUT  = 28'h4000000,
		ST_T_WAIT = 28'h8000000
	} state_t;

	state_t state_q;

	logic [30:0] vlim_q;
	logic [30:0] alim_q;
	logic [16:0] tick_q;
	logic [3:0]  jcnt_q;

	logic [3:0]  jdx_q;
	logic [31:0] dmax_q;
	logic [31:0] ta_q;
	logic [31:0] total_q;
	logic [31:0] elapsed_q;
	logic        finished_q;
	logic [65:0] wide_q;
	logic [31:0] vm_q;
	logic [31:0] am_q;
	logic [32:0] opa_q;
	logic [32:0] opb_q;
	logic [65:0] prod_q;

	logic [31:0] t_q;
	logic        done_q;
	logic [32:0] tx_q;
	logic [1:0]  seg_q;
	logic        neg_q;
	logic [31:0] q0_q;
	logic [31:0] qf_q;
	logic [40:0] v_q;
	logic [40:0] mv_q;
	logic [65:0] acc_q;
	logic [40:0] off_q;

	logic                         m_tvalid_q;
	logic [stmp_pkg::TDATA_W-1:0] m_tdata_q;
	logic                         m_tlast_q;
	logic                         m_tuser_q;

	logic [30:0] veff;
	logic [30:0] aeff;
	logic [3:0]  n_use;
	logic [3:0]  jdx_n1;
	logic        more;
	logic        s_acc;
	logic        cfg_wr;

	stmp_pkg::mem_wr_t ang_wr;
	stmp_pkg::mem_wr_t prof_wr;
	logic              prof_clr;
	logic [63:0]       ang_rdata;
	logic [63:0]       prof_rdata;

	logic        div_start;
	logic [63:0] div_num;
	logic [31:0] div_den;
	logic        div_busy;
	logic        div_done;
	logic [63:0] div_quot;
	logic        sq_start;
	logic        sq_done;
	logic [31:0] sq_root;

	logic [31:0] mag;
	logic        trap;
	logic        c_acc;
	logic        c_cru;
	logic        c_dec;
	logic [32:0] tx_n;
	logic [73:0] full;
	logic [31:0] root_sat;
	logic [32:0] el_sum;
	logic signed [43:0] offs;
	logic signed [43:0] q0s;
	logic signed [43:0] qfs;
	logic signed [43:0] pos_w;
	logic signed [43:0] vel_w;

	assign veff   = (vlim_q == '0) ? 31'd1 : vlim_q;
	assign aeff   = (alim_q == '0) ? 31'd1 : alim_q;
	assign n_use  = (jcnt_q == '0) ? 4'd1 :
		(jcnt_q > 4'(stmp_pkg::MAX_JOINTS)) ? 4'(stmp_pkg::MAX_JOINTS) : jcnt_q;
	assign jdx_n1 = jdx_q + 4'd1;
	assign more   = (jdx_n1 < n_use);
	assign s_acc  = s_tvalid && s_tready;
	assign cfg_wr = psel && penable && pwrite && pready;

	assign s_tready = (state_q == ST_IDLE);
	assign pready   = 1'b1;

	always_comb begin
		case (paddr[3:2])
			stmp_pkg::REG_VLIM: prdata = {1'b0, vlim_q};
			stmp_pkg::REG_ALIM: prdata = {1'b0, alim_q};
			stmp_pkg::REG_TICK: prdata = {15'd0, tick_q};
			stmp_pkg::REG_JCNT: prdata = {28'd0, jcnt_q};
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlim_q <= 31'd65536;
			alim_q <= 31'd131072;
			tick_q <= 17'd655;
			jcnt_q <= 4'd3;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				stmp_pkg::REG_VLIM: vlim_q <= pwdata[30:0];
				stmp_pkg::REG_ALIM: alim_q <= pwdata[30:0];
				stmp_pkg::REG_TICK: tick_q <= pwdata[16:0];
				stmp_pkg::REG_JCNT: jcnt_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	stmp_jstore u_jstore (
		.clk        (clk),
		.arst_n     (arst_n),
		.ang_wr     (ang_wr),
		.prof_wr    (prof_wr),
		.prof_clr   (prof_clr),
		.raddr      (jdx_q[2:0]),
		.ang_rdata  (ang_rdata),
		.prof_rdata (prof_rdata)
	);

	stmp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	stmp_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (div_quot),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_comb begin
		mag      = stmp_pkg::abs_diff(ang_rdata[31:0], ang_rdata[63:32]);
		trap     = (wide_q >= prod_q);
		root_sat = stmp_pkg::sat_time({34'd0, sq_root});
		c_acc    = (t_q <= ta_q);
		c_cru    = ({1'b0, t_q} + {1'b0, ta_q}) <= {1'b0, total_q};
		c_dec    = (t_q <= total_q);
		if (c_acc) begin
			tx_n = {1'b0, t_q};
		end else if (c_cru) begin
			tx_n = {t_q, 1'b0} - {1'b0, ta_q};
		end else begin
			tx_n = {1'b0, total_q - t_q};
		end
		full   = {8'd0, acc_q} + {prod_q[41:0], 32'd0};
		el_sum = {1'b0, elapsed_q} + 33'(tick_q);
		offs   = neg_q ? -44'(off_q) : 44'(off_q);
		q0s    = 44'(signed'(q0_q));
		qfs    = 44'(signed'(qf_q));
		vel_w  = neg_q ? -44'(v_q) : 44'(v_q);
		case (seg_q)
			stmp_pkg::SEG_ACC: pos_w = q0s + offs;
			stmp_pkg::SEG_CRU: pos_w = q0s + offs;
			stmp_pkg::SEG_DEC: pos_w = qfs - offs;
			default: begin
				pos_w = qfs;
				vel_w = '0;
			end
		endcase
	end

	always_comb begin
		ang_wr.we    = s_acc && !s_tuser[0];
		ang_wr.addr  = s_tdata[2:0];
		ang_wr.data  = {s_tdata[66:35], s_tdata[34:3]};
		prof_clr     = s_acc && !s_tuser[0] && s_tlast;
		prof_wr.we   = (state_q == ST_P_JWR);
		prof_wr.addr = jdx_q[2:0];
		prof_wr.data = {am_q, vm_q};
		div_start    = 1'b0;
		div_num      = '0;
		div_den      = {1'b0, aeff};
		sq_start     = 1'b0;
		case (state_q)
			ST_P_M3: begin
				div_start = 1'b1;
				div_num   = trap ? (64'(veff) << stmp_pkg::FRAC_BITS)
				                 : (64'(dmax_q) << (2 * stmp_pkg::FRAC_BITS));
			end
			ST_P_TA: begin
				div_start = div_done;
				div_num   = 64'(dmax_q) << stmp_pkg::FRAC_BITS;
				div_den   = {1'b0, veff};
			end
			ST_P_TRI: begin
				sq_start = div_done;
			end
			ST_P_JM2: begin
				div_start = 1'b1;
				div_num   = prod_q[63:0];
				div_den   = dmax_q;
			end
			ST_P_JVM: begin
				div_start = div_done && (ta_q != '0);
				div_num   = 64'(div_quot[31:0]) << stmp_pkg::FRAC_BITS;
				div_den   = ta_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else begin
			prod_q <= opa_q * opb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			jdx_q      <= '0;
			dmax_q     <= '0;
			ta_q       <= '0;
			total_q    <= '0;
			elapsed_q  <= '0;
			finished_q <= 1'b0;
			wide_q     <= '0;
			vm_q       <= '0;
			am_q       <= '0;
			opa_q      <= '0;
			opb_q      <= '0;
			t_q        <= '0;
			done_q     <= 1'b0;
			tx_q       <= '0;
			seg_q      <= stmp_pkg::SEG_END;
			neg_q      <= 1'b0;
			q0_q       <= '0;
			qf_q       <= '0;
			v_q        <= '0;
			mv_q       <= '0;
			acc_q      <= '0;
			off_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					jdx_q <= '0;
					if (s_acc && !s_tuser[0]) begin
						if (s_tlast) begin
							elapsed_q  <= '0;
							finished_q <= 1'b0;
							dmax_q     <= '0;
							state_q    <= ST_P_RD;
						end
					end else if (s_acc) begin
						if (elapsed_q > total_q) begin
							if (!finished_q) begin
								t_q        <= total_q;
								done_q     <= 1'b1;
								finished_q <= 1'b1;
								state_q    <= ST_T_RD;
							end
						end else begin
							t_q     <= elapsed_q;
							done_q  <= 1'b0;
							state_q <= ST_T_RD;
						end
					end
				end
				ST_P_RD: state_q <= ST_P_MAG;
				ST_P_MAG: begin
					if (mag > dmax_q) begin
						dmax_q <= mag;
					end
					if (more) begin
						jdx_q   <= jdx_n1;
						state_q <= ST_P_RD;
					end else begin
						state_q <= ST_P_CHK;
					end
				end
				ST_P_CHK: begin
					if (dmax_q == '0) begin
						ta_q    <= '0;
						total_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						opa_q   <= {1'b0, dmax_q};
						opb_q   <= {2'b0, aeff};
						state_q <= ST_P_M1;
					end
				end
				ST_P_M1: begin
					opa_q   <= {2'b0, veff};
					opb_q   <= {2'b0, veff};
					state_q <= ST_P_M2;
				end
				ST_P_M2: begin
					wide_q  <= prod_q;
					state_q <= ST_P_M3;
				end
				ST_P_M3: state_q <= trap ? ST_P_TA : ST_P_TRI;
				ST_P_TA: begin
					if (div_done) begin
						wide_q  <= {2'b0, div_quot};
						ta_q    <= stmp_pkg::sat_time({2'b0, div_quot});
						state_q <= ST_P_TT;
					end
				end
				ST_P_TT: begin
					if (div_done) begin
						total_q <= stmp_pkg::sat_time(wide_q + {2'b0, div_quot});
						jdx_q   <= '0;
						state_q <= ST_P_JRD;
					end
				end
				ST_P_TRI: begin
					if (div_done) begin
						state_q <= ST_P_SQ;
					end
				end
				ST_P_SQ: begin
					if (sq_done) begin
						ta_q    <= root_sat;
						total_q <= stmp_pkg::sat_time({33'd0, root_sat, 1'b0});
						jdx_q   <= '0;
						state_q <= ST_P_JRD;
					end
				end
				ST_P_JRD: state_q <= ST_P_JMAG;
				ST_P_JMAG: begin
					opa_q   <= {1'b0, mag};
					opb_q   <= {2'b0, veff};
					state_q <= ST_P_JM1;
				end
				ST_P_JM1: state_q <= ST_P_JM2;
				ST_P_JM2: state_q <= ST_P_JVM;
				ST_P_JVM: begin
					if (div_done) begin
						vm_q <= div_quot[31:0];
						am_q <= '0;
						state_q <= (ta_q == '0) ? ST_P_JWR : ST_P_JAM;
					end
				end
				ST_P_JAM: begin
					if (div_done) begin
						am_q <= (div_quot[63:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
						state_q <= ST_P_JWR;
					end
				end
				ST_P_JWR: begin
					if (more) begin
						jdx_q   <= jdx_n1;
						state_q <= ST_P_JRD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_T_RD: state_q <= ST_T_LD;
				ST_T_LD: begin
					q0_q  <= ang_rdata[31:0];
					qf_q  <= ang_rdata[63:32];
					neg_q <= ($signed(ang_rdata[63:32]) < $signed(ang_rdata[31:0]));
					tx_q  <= tx_n;
					opa_q <= {1'b0, prof_rdata[63:32]};
					opb_q <= tx_n;
					if (c_acc) begin
						seg_q   <= stmp_pkg::SEG_ACC;
						state_q <= ST_T_V1;
					end else if (c_cru) begin
						seg_q   <= stmp_pkg::SEG_CRU;
						v_q     <= 41'(prof_rdata[31:0]);
						mv_q    <= 41'(prof_rdata[31:0]);
						state_q <= ST_T_O0;
					end else if (c_dec) begin
						seg_q   <= stmp_pkg::SEG_DEC;
						state_q <= ST_T_V1;
					end else begin
						seg_q   <= stmp_pkg::SEG_END;
						state_q <= ST_T_OUT;
					end
				end
				ST_T_V1: state_q <= ST_T_V2;
				ST_T_V2: begin
					v_q     <= stmp_pkg::sat_wide(74'(prod_q >> stmp_pkg::FRAC_BITS));
					mv_q    <= stmp_pkg::sat_wide(74'(prod_q >> stmp_pkg::FRAC_BITS));
					state_q <= ST_T_O0;
				end
				ST_T_O0: begin
					opa_q   <= {1'b0, mv_q[31:0]};
					opb_q   <= tx_q;
					state_q <= ST_T_O1;
				end
				ST_T_O1: begin
					opa_q   <= {24'd0, mv_q[40:32]};
					opb_q   <= tx_q;
					state_q <= ST_T_O2;
				end
				ST_T_O2: begin
					acc_q   <= prod_q;
					state_q <= ST_T_O3;
				end
				ST_T_O3: begin
					off_q   <= stmp_pkg::sat_wide(full >> (stmp_pkg::FRAC_BITS + 1));
					state_q <= ST_T_OUT;
				end
				ST_T_OUT: begin
					m_tvalid_q <= 1'b1;
					m_tdata_q  <= {5'd0, stmp_pkg::clamp32(vel_w),
						stmp_pkg::clamp32(pos_w), jdx_q[2:0]};
					m_tlast_q  <= !more;
					m_tuser_q  <= done_q;
					state_q    <= ST_T_WAIT;
				end
				ST_T_WAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (more) begin
							jdx_q   <= jdx_n1;
							state_q <= ST_T_RD;
						end else begin
							if (!done_q) begin
								elapsed_q <= el_sum[32] ? stmp_pkg::ELAPSED_MAX
								                        : el_sum[31:0];
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tlast    = m_tlast_q;
	assign m_tuser[0] = m_tuser_q;

	`STMP_ASSERT_ALWAYS(a_in_out_excl, !(s_tready && m_tvalid))
	`STMP_ASSERT(a_done_final, (m_tvalid && m_tuser[0]) |-> finished_q)
	`STMP_ASSERT(a_div_free, div_start |-> !div_busy)
	`STMP_ASSERT(a_plan_order, (state_q == ST_IDLE) |-> (ta_q <= total_q))

endmodule
